### rtl/tksd_pkg.sv
// Package for the terminal key sequence decoder: types, codes and helper functions.
`timescale 1ns / 1ps
package tksd_pkg;

  localparam int unsigned MaxUtf8Bytes = 6;
  localparam int unsigned ValueW       = 31;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_ESC      = 4'd1,
    ST_ESC_ESC  = 4'd2,
    ST_INTRO    = 4'd3,
    ST_DIGIT    = 4'd4,
    ST_TEN      = 4'd5,
    ST_TWENTY   = 4'd6,
    ST_BRACKET2 = 4'd7,
    ST_UTF8     = 4'd8
  } state_e;

  typedef enum logic [2:0] {
    KIND_CHAR    = 3'd0,
    KIND_CODE    = 3'd1,
    KIND_NAMED   = 3'd2,
    KIND_FN      = 3'd3,
    KIND_IGNORED = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_e;

  // named key codes
  localparam logic [ValueW-1:0] NK_ESC       = 31'd0;
  localparam logic [ValueW-1:0] NK_UP        = 31'd1;
  localparam logic [ValueW-1:0] NK_DOWN      = 31'd2;
  localparam logic [ValueW-1:0] NK_RIGHT     = 31'd3;
  localparam logic [ValueW-1:0] NK_LEFT      = 31'd4;
  localparam logic [ValueW-1:0] NK_HOME      = 31'd5;
  localparam logic [ValueW-1:0] NK_END       = 31'd6;
  localparam logic [ValueW-1:0] NK_INSERT    = 31'd7;
  localparam logic [ValueW-1:0] NK_DELETE    = 31'd8;
  localparam logic [ValueW-1:0] NK_PGUP      = 31'd9;
  localparam logic [ValueW-1:0] NK_PGDN      = 31'd10;
  localparam logic [ValueW-1:0] NK_BACKSPACE = 31'd11;
  localparam logic [ValueW-1:0] FN_LAST      = 31'd12;

  // byte codes
  localparam logic [7:0] B_ESC     = 8'h1B;
  localparam logic [7:0] B_DEL     = 8'h7F;
  localparam logic [7:0] B_LBRACK  = 8'h5B;
  localparam logic [7:0] B_O       = 8'h4F;
  localparam logic [7:0] B_TILDE   = 8'h7E;
  localparam logic [7:0] B_LOW_H   = 8'h68;
  localparam logic [7:0] B_LOW_A   = 8'h61;
  localparam logic [7:0] B_LOW_Z   = 8'h7A;
  localparam logic [7:0] B_0       = 8'h30;
  localparam logic [7:0] B_1       = 8'h31;
  localparam logic [7:0] B_2       = 8'h32;
  localparam logic [7:0] B_3       = 8'h33;
  localparam logic [7:0] B_4       = 8'h34;
  localparam logic [7:0] B_5       = 8'h35;
  localparam logic [7:0] B_6       = 8'h36;
  localparam logic [7:0] B_7       = 8'h37;
  localparam logic [7:0] B_8       = 8'h38;
  localparam logic [7:0] B_9       = 8'h39;
  localparam logic [7:0] B_A       = 8'h41;
  localparam logic [7:0] B_B       = 8'h42;
  localparam logic [7:0] B_C       = 8'h43;
  localparam logic [7:0] B_D       = 8'h44;
  localparam logic [7:0] B_E       = 8'h45;
  localparam logic [7:0] B_F       = 8'h46;
  localparam logic [7:0] B_H       = 8'h48;
  localparam logic [7:0] B_P       = 8'h50;
  localparam logic [7:0] B_Q       = 8'h51;
  localparam logic [7:0] B_R       = 8'h52;
  localparam logic [7:0] B_S       = 8'h53;
  localparam logic [7:0] B_FN_BASE = 8'h40;

  typedef struct packed {
    state_e            st;
    logic [7:0]        second_byte;
    logic [7:0]        third_byte;
    logic [ValueW-1:0] acc;
    logic [2:0]        remaining;
    logic [2:0]        seq_len;
    logic              invalid;
  } dec_state_t;

  typedef struct packed {
    kind_e             kind;
    logic [ValueW-1:0] value;
  } key_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if (b >= 8'hC0 && b <= 8'hDF) len = 3'd2;
    else if (b >= 8'hE0 && b <= 8'hEF) len = 3'd3;
    else if (b >= 8'hF0 && b <= 8'hF7) len = 3'd4;
    else if (b >= 8'hF8 && b <= 8'hFB) len = 3'd5;
    else if (b >= 8'hFC && b <= 8'hFD) len = 3'd6;
    return len;
  endfunction

  // value subtracted from the gathered bits, by sequence length, mod 2^31
  function automatic logic [ValueW-1:0] utf8_offset(input logic [2:0] len);
    logic [31:0] off;
    case (len)
      3'd2:    off = 32'h0000_3080;
      3'd3:    off = 32'h000E_2080;
      3'd4:    off = 32'h03C8_2080;
      3'd5:    off = 32'hFA08_2080;
      3'd6:    off = 32'h8208_2080;
      default: off = 32'h0000_0000;
    endcase
    return off[ValueW-1:0];
  endfunction

endpackage

### rtl/tksd_if.sv
// Valid/ready channel interfaces for input bytes and decoded keys.
`timescale 1ns / 1ps
interface tksd_byte_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_value;

  modport source (output valid, output op, output byte_value, input ready);
  modport sink (input valid, input op, input byte_value, output ready);
endinterface

interface tksd_key_if;
  logic        valid;
  logic        ready;
  logic [2:0]  key_kind;
  logic [30:0] key_value;

  modport source (output valid, output key_kind, output key_value, input ready);
  modport sink (input valid, input key_kind, input key_value, output ready);
endinterface

### rtl/tksd_step.sv
// Next-state and result logic for one input beat.
`timescale 1ns / 1ps
module tksd_step (
  input  tksd_pkg::dec_state_t cur_i,
  input  logic                 op_i,
  input  logic [7:0]           byte_i,
  output tksd_pkg::dec_state_t nxt_o,
  output logic                 res_vld_o,
  output tksd_pkg::key_t       res_o
);
  import tksd_pkg::*;

  logic              tick;
  logic [2:0]        len;
  logic              cont;
  logic [ValueW-1:0] acc_n;
  logic [2:0]        rem_n;
  logic              inv_n;

  assign tick = op_i;
  assign len  = lead_length(byte_i);
  assign cont = (byte_i[7:6] == 2'b10);

  always_comb begin
    acc_n = cur_i.acc;
    if (cont) acc_n = {cur_i.acc[ValueW-7:0], 6'd0} + {23'd0, byte_i};
    rem_n = (cur_i.remaining != 3'd0) ? cur_i.remaining - 3'd1 : cur_i.remaining;
    inv_n = cur_i.invalid | ~cont;
  end

  always_comb begin
    nxt_o     = cur_i;
    res_vld_o = 1'b0;
    res_o     = '{kind: KIND_IGNORED, value: '0};
    case (cur_i.st)
      ST_ESC: begin
        if (tick) begin
          res_vld_o = 1'b1; res_o = '{kind: KIND_NAMED, value: NK_ESC};
        end else if (byte_i >= B_LOW_A && byte_i <= B_LOW_Z) begin
          res_vld_o = 1'b1;
        end else if (byte_i == B_ESC) begin
          nxt_o.st = ST_ESC_ESC;
        end else if (byte_i == B_LBRACK || byte_i == B_O) begin
          nxt_o.second_byte = byte_i;
          nxt_o.st = ST_INTRO;
        end else begin
          res_vld_o = 1'b1;
        end
      end
      ST_ESC_ESC: begin
        if (!tick && (byte_i == B_LBRACK || byte_i == B_O)) begin
          nxt_o.second_byte = byte_i;
          nxt_o.st = ST_INTRO;
        end else begin
          res_vld_o = 1'b1;
        end
      end
      ST_INTRO: begin
        if (tick) begin
          res_vld_o = 1'b1; res_o = '{kind: KIND_NAMED, value: NK_ESC};
        end else if (cur_i.second_byte == B_LBRACK && byte_i >= B_0 && byte_i <= B_9) begin
          nxt_o.third_byte = byte_i;
          nxt_o.st = ST_DIGIT;
        end else if (cur_i.second_byte == B_LBRACK && byte_i == B_LBRACK) begin
          nxt_o.st = ST_BRACKET2;
        end else begin
          res_vld_o = 1'b1;
          case (byte_i)
            B_A: res_o = '{kind: KIND_NAMED, value: NK_UP};
            B_B: res_o = '{kind: KIND_NAMED, value: NK_DOWN};
            B_C: res_o = '{kind: KIND_NAMED, value: NK_RIGHT};
            B_D: res_o = '{kind: KIND_NAMED, value: NK_LEFT};
            B_H: res_o = '{kind: KIND_NAMED, value: NK_HOME};
            B_F: res_o = '{kind: KIND_NAMED, value: NK_END};
            B_P: begin
              if (cur_i.second_byte == B_LBRACK) res_o = '{kind: KIND_NAMED, value: NK_DELETE};
              else res_o = '{kind: KIND_FN, value: 31'd1};
            end
            B_Q: if (cur_i.second_byte != B_LBRACK) res_o = '{kind: KIND_FN, value: 31'd2};
            B_R: if (cur_i.second_byte != B_LBRACK) res_o = '{kind: KIND_FN, value: 31'd3};
            B_S: if (cur_i.second_byte != B_LBRACK) res_o = '{kind: KIND_FN, value: 31'd4};
            default: res_o = '{kind: KIND_IGNORED, value: '0};
          endcase
        end
      end
      ST_DIGIT: begin
        if (tick) begin
          res_vld_o = 1'b1; res_o = '{kind: KIND_NAMED, value: NK_ESC};
        end else if (byte_i == B_TILDE) begin
          res_vld_o = 1'b1;
          case (cur_i.third_byte)
            B_1, B_7: res_o = '{kind: KIND_NAMED, value: NK_HOME};
            B_2:      res_o = '{kind: KIND_NAMED, value: NK_INSERT};
            B_3:      res_o = '{kind: KIND_NAMED, value: NK_DELETE};
            B_4, B_8: res_o = '{kind: KIND_NAMED, value: NK_END};
            B_5:      res_o = '{kind: KIND_NAMED, value: NK_PGUP};
            B_6:      res_o = '{kind: KIND_NAMED, value: NK_PGDN};
            default:  res_o = '{kind: KIND_IGNORED, value: '0};
          endcase
        end else if (cur_i.third_byte == B_1 || cur_i.third_byte == B_2) begin
          nxt_o.st = (cur_i.third_byte == B_1) ? ST_TEN : ST_TWENTY;
          nxt_o.third_byte = byte_i;
        end else begin
          res_vld_o = 1'b1;
          if (byte_i == B_LOW_H) res_o = '{kind: KIND_NAMED, value: NK_INSERT};
        end
      end
      ST_TEN: begin
        res_vld_o = 1'b1;
        if (tick) res_o = '{kind: KIND_NAMED, value: NK_ESC};
        else begin
          case (cur_i.third_byte)
            B_1:     res_o = '{kind: KIND_FN, value: 31'd1};
            B_2:     res_o = '{kind: KIND_FN, value: 31'd2};
            B_3:     res_o = '{kind: KIND_FN, value: 31'd3};
            B_4:     res_o = '{kind: KIND_FN, value: 31'd4};
            B_5:     res_o = '{kind: KIND_FN, value: 31'd5};
            B_7:     res_o = '{kind: KIND_FN, value: 31'd6};
            B_8:     res_o = '{kind: KIND_FN, value: 31'd7};
            B_9:     res_o = '{kind: KIND_FN, value: 31'd8};
            default: res_o = '{kind: KIND_IGNORED, value: '0};
          endcase
        end
      end
      ST_TWENTY: begin
        res_vld_o = 1'b1;
        if (tick) res_o = '{kind: KIND_NAMED, value: NK_ESC};
        else begin
          case (cur_i.third_byte)
            B_0:     res_o = '{kind: KIND_FN, value: 31'd9};
            B_1:     res_o = '{kind: KIND_FN, value: 31'd10};
            B_3:     res_o = '{kind: KIND_FN, value: 31'd11};
            B_4:     res_o = '{kind: KIND_FN, value: 31'd12};
            default: res_o = '{kind: KIND_IGNORED, value: '0};
          endcase
        end
      end
      ST_BRACKET2: begin
        res_vld_o = 1'b1;
        if (tick) res_o = '{kind: KIND_NAMED, value: NK_ESC};
        else if (byte_i >= B_A && byte_i <= B_E)
          res_o = '{kind: KIND_FN, value: {23'd0, byte_i - B_FN_BASE}};
      end
      ST_UTF8: begin
        if (tick) begin
          res_vld_o = 1'b1; res_o = '{kind: KIND_ERROR, value: '0};
        end else begin
          nxt_o.acc       = acc_n;
          nxt_o.invalid   = inv_n;
          nxt_o.remaining = rem_n;
          if (rem_n == 3'd0) begin
            res_vld_o = 1'b1;
            if (inv_n || cur_i.seq_len == 3'd0 || cur_i.seq_len == 3'd7)
              res_o = '{kind: KIND_ERROR, value: '0};
            else
              res_o = '{kind: KIND_CODE, value: acc_n - utf8_offset(cur_i.seq_len)};
          end
        end
      end
      default: begin
        nxt_o.st = ST_IDLE;
        if (!tick) begin
          if (byte_i == B_ESC) begin
            nxt_o.st = ST_ESC;
          end else if (byte_i[7]) begin
            if (32'(len) > MaxUtf8Bytes) begin
              res_vld_o = 1'b1; res_o = '{kind: KIND_ERROR, value: '0};
            end else if (len == 3'd1) begin
              res_vld_o = 1'b1; res_o = '{kind: KIND_CODE, value: {23'd0, byte_i}};
            end else begin
              nxt_o.acc       = {23'd0, byte_i};
              nxt_o.remaining = len - 3'd1;
              nxt_o.seq_len   = len;
              nxt_o.invalid   = 1'b0;
              nxt_o.st        = ST_UTF8;
            end
          end else if (byte_i == B_DEL) begin
            res_vld_o = 1'b1; res_o = '{kind: KIND_NAMED, value: NK_BACKSPACE};
          end else begin
            res_vld_o = 1'b1; res_o = '{kind: KIND_CHAR, value: {23'd0, byte_i}};
          end
        end
      end
    endcase
    // any result ends the sequence
    if (res_vld_o) nxt_o.st = ST_IDLE;
  end

endmodule

### rtl/tksd_core.sv
// Parser state registers, advanced once per decoded beat.
`timescale 1ns / 1ps
module tksd_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           op_i,
  input  logic [7:0]     byte_i,
  output logic           res_vld_o,
  output tksd_pkg::key_t res_o
);
  import tksd_pkg::*;

  dec_state_t state_q;
  dec_state_t state_d;

  tksd_step u_step (
    .cur_i     (state_q),
    .op_i      (op_i),
    .byte_i    (byte_i),
    .nxt_o     (state_d),
    .res_vld_o (res_vld_o),
    .res_o     (res_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{st: ST_IDLE, second_byte: '0, third_byte: '0, acc: '0,
                   remaining: '0, seq_len: '0, invalid: 1'b0};
    end else if (en_i) begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/terminal_key_sequence_decoder.sv
// Top level of the terminal key sequence decoder: input stage, parser, result register.
//
//   channel  dir  payload                    beat taken when
//   in_i     in   op, byte_value             in_i.valid && in_i.ready
//   out_o    out  key_kind, key_value        out_o.valid && out_o.ready
//
// One beat per cycle sustained while out_o is not stalled.
// The input register feeds the parser, which writes the result register.
// Beats that close no key (mid-sequence bytes, idle timeouts) give no result.
// Reset puts the parser in idle and empties both stages.
// A stalled result holds the parser; the input stage then fills and drops ready.
`timescale 1ns / 1ps
module terminal_key_sequence_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  tksd_byte_if.sink  in_i,
  tksd_key_if.source out_o
);
  import tksd_pkg::*;

  logic       in_vld_q;
  logic       in_op_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  key_t       out_q;
  logic       adv;
  logic       res_vld;
  key_t       res;

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_op_q   <= in_i.op;
      in_byte_q <= in_i.byte_value;
    end
  end

  tksd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .op_i      (in_op_q),
    .byte_i    (in_byte_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res_vld;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.key_kind  = out_q.kind;
  assign out_o.key_value = out_q.value;

  a_stall_keeps_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_byte_q) && $stable(in_op_q))
    else $error("pending input beat lost while stalled");

  a_empty_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.kind == KIND_IGNORED || out_q.kind == KIND_ERROR)
      |-> out_q.value == '0)
    else $error("ignored or error result with nonzero value");

  a_fn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.kind == KIND_FN |-> out_q.value != '0 && out_q.value <= FN_LAST)
    else $error("function key number out of range");

  a_named_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.kind == KIND_NAMED |-> out_q.value <= NK_BACKSPACE)
    else $error("named key code out of range");

  a_char_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.kind == KIND_CHAR |-> out_q.value < 31'd128 &&
      out_q.value != {23'd0, B_ESC} && out_q.value != {23'd0, B_DEL})
    else $error("plain char outside seven-bit range");

endmodule

### dv/tksd_key_checker.sv
// Checker for the terminal key decoder: predicts keys from input beats and compares output beats.
`timescale 1ns / 1ps
module tksd_key_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tksd_byte_if        byte_mon,
  tksd_key_if         key_mon,
  output int unsigned err_count_o,
  output int unsigned pending_o
);
  import tksd_pkg::*;

  state_e      pst;
  logic [7:0]  intro_q;
  logic [7:0]  digit_q;
  logic [31:0] acc_q;
  logic [2:0]  left_q;
  logic [2:0]  len_q;
  logic        bad_q;
  key_t        expected_keys[$];
  int unsigned errs;

  function automatic logic [2:0] lead_bytes(input logic [7:0] b);
    casez (b)
      8'b110?_????: return 3'd2;
      8'b1110_????: return 3'd3;
      8'b1111_0???: return 3'd4;
      8'b1111_10??: return 3'd5;
      8'b1111_110?: return 3'd6;
      default:      return 3'd1;
    endcase
  endfunction

  function automatic logic [31:0] length_bias(input logic [2:0] len);
    case (len)
      3'd2:    return 32'h0000_3080;
      3'd3:    return 32'h000E_2080;
      3'd4:    return 32'h03C8_2080;
      3'd5:    return 32'hFA08_2080;
      3'd6:    return 32'h8208_2080;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // advance the key parser by one beat; got is set when the beat closes a key
  function automatic void decode_beat(input logic tick, input logic [7:0] b,
                                      output logic got, output key_t k);
    kind_e             kk;
    logic [ValueW-1:0] vv;
    logic [2:0]        n;
    got = 1'b1;
    kk  = KIND_IGNORED;
    vv  = '0;
    case (pst)
      ST_ESC: begin
        if (tick) begin
          kk = KIND_NAMED;
          vv = NK_ESC;
        end else if (b >= B_LOW_A && b <= B_LOW_Z) begin
          kk = KIND_IGNORED;
        end else if (b == B_ESC) begin
          got = 1'b0;
          pst = ST_ESC_ESC;
        end else if (b == B_LBRACK || b == B_O) begin
          got     = 1'b0;
          intro_q = b;
          pst     = ST_INTRO;
        end
      end
      ST_ESC_ESC: begin
        if (!tick && (b == B_LBRACK || b == B_O)) begin
          got     = 1'b0;
          intro_q = b;
          pst     = ST_INTRO;
        end
      end
      ST_INTRO: begin
        if (tick) begin
          kk = KIND_NAMED;
          vv = NK_ESC;
        end else if (intro_q == B_LBRACK) begin
          if (b >= B_0 && b <= B_9) begin
            got     = 1'b0;
            digit_q = b;
            pst     = ST_DIGIT;
          end else if (b == B_LBRACK) begin
            got = 1'b0;
            pst = ST_BRACKET2;
          end else begin
            kk = KIND_NAMED;
            case (b)
              B_A:     vv = NK_UP;
              B_B:     vv = NK_DOWN;
              B_C:     vv = NK_RIGHT;
              B_D:     vv = NK_LEFT;
              B_H:     vv = NK_HOME;
              B_F:     vv = NK_END;
              B_P:     vv = NK_DELETE;
              default: kk = KIND_IGNORED;
            endcase
          end
        end else begin
          kk = KIND_NAMED;
          case (b)
            B_A: vv = NK_UP;
            B_B: vv = NK_DOWN;
            B_C: vv = NK_RIGHT;
            B_D: vv = NK_LEFT;
            B_H: vv = NK_HOME;
            B_F: vv = NK_END;
            B_P: begin kk = KIND_FN; vv = 31'd1; end
            B_Q: begin kk = KIND_FN; vv = 31'd2; end
            B_R: begin kk = KIND_FN; vv = 31'd3; end
            B_S: begin kk = KIND_FN; vv = 31'd4; end
            default: kk = KIND_IGNORED;
          endcase
        end
      end
      ST_DIGIT: begin
        if (tick) begin
          kk = KIND_NAMED;
          vv = NK_ESC;
        end else if (b == B_TILDE) begin
          kk = KIND_NAMED;
          case (digit_q)
            B_1:     vv = NK_HOME;
            B_2:     vv = NK_INSERT;
            B_3:     vv = NK_DELETE;
            B_4:     vv = NK_END;
            B_5:     vv = NK_PGUP;
            B_6:     vv = NK_PGDN;
            B_7:     vv = NK_HOME;
            B_8:     vv = NK_END;
            default: kk = KIND_IGNORED;
          endcase
        end else if (digit_q == B_1 || digit_q == B_2) begin
          got     = 1'b0;
          pst     = (digit_q == B_1) ? ST_TEN : ST_TWENTY;
          digit_q = b;
        end else if (b == B_LOW_H) begin
          kk = KIND_NAMED;
          vv = NK_INSERT;
        end
      end
      ST_TEN: begin
        if (tick) begin
          kk = KIND_NAMED;
          vv = NK_ESC;
        end else begin
          kk = KIND_FN;
          case (digit_q)
            B_1:     vv = 31'd1;
            B_2:     vv = 31'd2;
            B_3:     vv = 31'd3;
            B_4:     vv = 31'd4;
            B_5:     vv = 31'd5;
            B_7:     vv = 31'd6;
            B_8:     vv = 31'd7;
            B_9:     vv = 31'd8;
            default: kk = KIND_IGNORED;
          endcase
        end
      end
      ST_TWENTY: begin
        if (tick) begin
          kk = KIND_NAMED;
          vv = NK_ESC;
        end else begin
          kk = KIND_FN;
          case (digit_q)
            B_0:     vv = 31'd9;
            B_1:     vv = 31'd10;
            B_3:     vv = 31'd11;
            B_4:     vv = FN_LAST;
            default: kk = KIND_IGNORED;
          endcase
        end
      end
      ST_BRACKET2: begin
        if (tick) begin
          kk = KIND_NAMED;
          vv = NK_ESC;
        end else if (b >= B_A && b <= B_E) begin
          kk = KIND_FN;
          vv = ValueW'(b) - ValueW'(B_FN_BASE);
        end
      end
      ST_UTF8: begin
        if (tick) begin
          kk = KIND_ERROR;
        end else begin
          if (b[7:6] == 2'b10) acc_q = (acc_q << 6) + 32'(b);
          else bad_q = 1'b1;
          if (left_q != 3'd0) left_q = left_q - 3'd1;
          if (left_q != 3'd0) begin
            got = 1'b0;
          end else if (bad_q) begin
            kk = KIND_ERROR;
          end else begin
            kk = KIND_CODE;
            vv = ValueW'(acc_q - length_bias(len_q));
          end
        end
      end
      default: begin
        pst = ST_IDLE;
        if (tick) begin
          got = 1'b0;
        end else if (b == B_ESC) begin
          got = 1'b0;
          pst = ST_ESC;
        end else if (b[7]) begin
          n = lead_bytes(b);
          if (n > MaxUtf8Bytes) begin
            kk = KIND_ERROR;
          end else if (n == 3'd1) begin
            kk = KIND_CODE;
            vv = ValueW'(b);
          end else begin
            got    = 1'b0;
            acc_q  = 32'(b);
            left_q = n - 3'd1;
            len_q  = n;
            bad_q  = 1'b0;
            pst    = ST_UTF8;
          end
        end else if (b == B_DEL) begin
          kk = KIND_NAMED;
          vv = NK_BACKSPACE;
        end else begin
          kk = KIND_CHAR;
          vv = ValueW'(b);
        end
      end
    endcase
    if (got) pst = ST_IDLE;
    k.kind  = kk;
    k.value = vv;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic got;
    key_t k;
    key_t want;
    if (!rst_ni) begin
      pst     = ST_IDLE;
      intro_q = '0;
      digit_q = '0;
      acc_q   = '0;
      left_q  = '0;
      len_q   = '0;
      bad_q   = 1'b0;
      expected_keys.delete();
      errs        = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (key_mon.valid && key_mon.ready) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: unexpected key beat: expected none, got kind %0d value 0x%0h",
                   $time, key_mon.key_kind, key_mon.key_value);
          errs++;
        end else begin
          want = expected_keys.pop_front();
          if (key_mon.key_kind !== want.kind || key_mon.key_value !== want.value) begin
            $display("%0t: key mismatch: expected kind %0d value 0x%0h, got kind %0d value 0x%0h",
                     $time, want.kind, want.value, key_mon.key_kind, key_mon.key_value);
            errs++;
          end
        end
      end
      if (byte_mon.valid && byte_mon.ready) begin
        decode_beat(byte_mon.op, byte_mon.byte_value, got, k);
        if (got) expected_keys.push_back(k);
      end
      err_count_o <= errs;
      pending_o   <= expected_keys.size();
    end
  end

endmodule

### dv/tb.sv
// Top of the terminal key decoder testbench: clock, reset, byte stimulus, key sink and verdict.
`timescale 1ns / 1ps
module tb;
  import tksd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumBeats   = 1850;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } beat_t;

  logic        clk;
  logic        rst_n;
  int unsigned errs;
  int unsigned pending;
  beat_t       stim_q[$];

  tksd_byte_if byte_ch ();
  tksd_key_if  key_ch ();

  terminal_key_sequence_decoder dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_ch),
    .out_o (key_ch)
  );

  tksd_key_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .byte_mon   (byte_ch),
    .key_mon    (key_ch),
    .err_count_o(errs),
    .pending_o  (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic add_beat(input logic op, input logic [7:0] data);
    stim_q.push_back('{op: op, data: data});
  endtask

  // one random key sequence, mostly well formed, sometimes cut short by a timeout
  task automatic add_sequence();
    logic [7:0]  s[$];
    logic [7:0]  bad;
    int unsigned pick, n, cut, k, digit;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      s.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 18) begin
      s.push_back(8'($urandom_range(32, 126)));
    end else if (pick < 20) begin
      s.push_back(($urandom_range(0, 1) != 0) ? B_DEL : 8'($urandom_range(0, 31)));
    end else if (pick < 30) begin
      s.push_back(B_ESC);
      s.push_back(B_LBRACK);
      case ($urandom_range(0, 7))
        0:       s.push_back(B_A);
        1:       s.push_back(B_B);
        2:       s.push_back(B_C);
        3:       s.push_back(B_D);
        4:       s.push_back(B_H);
        5:       s.push_back(B_F);
        6:       s.push_back(B_P);
        default: s.push_back(8'($urandom_range(0, 255)));
      endcase
    end else if (pick < 38) begin
      s.push_back(B_ESC);
      s.push_back(B_O);
      case ($urandom_range(0, 10))
        0:       s.push_back(B_A);
        1:       s.push_back(B_B);
        2:       s.push_back(B_C);
        3:       s.push_back(B_D);
        4:       s.push_back(B_F);
        5:       s.push_back(B_H);
        6:       s.push_back(B_P);
        7:       s.push_back(B_Q);
        8:       s.push_back(B_R);
        9:       s.push_back(B_S);
        default: s.push_back(8'($urandom_range(0, 255)));
      endcase
    end else if (pick < 48) begin
      digit = $urandom_range(0, 9);
      s.push_back(B_ESC);
      s.push_back(B_LBRACK);
      s.push_back(B_0 + 8'(digit));
      n = $urandom_range(0, 99);
      if (n < 70) s.push_back(B_TILDE);
      else if (n < 85) s.push_back(B_LOW_H);
      else s.push_back(8'($urandom_range(0, 255)));
      if ((digit == 1 || digit == 2) && s[s.size()-1] != B_TILDE) s.push_back(B_TILDE);
    end else if (pick < 58) begin
      s.push_back(B_ESC);
      s.push_back(B_LBRACK);
      s.push_back(($urandom_range(0, 1) != 0) ? B_2 : B_1);
      s.push_back(B_0 + 8'($urandom_range(0, 9)));
      s.push_back(($urandom_range(0, 99) < 80) ? B_TILDE : 8'($urandom_range(0, 255)));
    end else if (pick < 64) begin
      s.push_back(B_ESC);
      s.push_back(B_LBRACK);
      s.push_back(B_LBRACK);
      if ($urandom_range(0, 99) < 80) s.push_back(8'($urandom_range(B_A, B_E)));
      else s.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 70) begin
      s.push_back(B_ESC);
      s.push_back(B_ESC);
      if ($urandom_range(0, 99) < 75) begin
        s.push_back(($urandom_range(0, 1) != 0) ? B_LBRACK : B_O);
        s.push_back(8'($urandom_range(B_A, B_S)));
      end else begin
        s.push_back(8'($urandom_range(0, 255)));
      end
    end else if (pick < 74) begin
      s.push_back(B_ESC);
      if ($urandom_range(0, 99) < 60) s.push_back(8'($urandom_range(B_LOW_A, B_LOW_Z)));
      else s.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      n = $urandom_range(2, MaxUtf8Bytes);
      case (n)
        2:       s.push_back(8'hC0 | 8'($urandom_range(0, 31)));
        3:       s.push_back(8'hE0 | 8'($urandom_range(0, 15)));
        4:       s.push_back(8'hF0 | 8'($urandom_range(0, 7)));
        5:       s.push_back(8'hF8 | 8'($urandom_range(0, 3)));
        default: s.push_back(8'hFC | 8'($urandom_range(0, 1)));
      endcase
      for (k = 1; k < n; k++) s.push_back(8'h80 | 8'($urandom_range(0, 63)));
      if ($urandom_range(0, 99) < 15) begin
        bad = 8'($urandom_range(0, 255));
        if (bad[7:6] == 2'b10) bad[6] = 1'b1;
        s[$urandom_range(1, n - 1)] = bad;
      end
    end else begin
      if ($urandom_range(0, 99) < 70) s.push_back(8'h80 | 8'($urandom_range(0, 63)));
      else s.push_back(8'($urandom_range(8'hFE, 8'hFF)));
    end
    n = $urandom_range(0, 99);
    if (n < 10) begin
      cut = $urandom_range(1, s.size());
      while (s.size() > cut) void'(s.pop_back());
    end
    foreach (s[i]) add_beat(1'b0, s[i]);
    if (n < 15) add_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // stimulus, reset and verdict
  initial begin
    int unsigned sent;
    rst_n              <= 1'b0;
    byte_ch.valid      <= 1'b0;
    byte_ch.op         <= 1'b0;
    byte_ch.byte_value <= 8'h00;

    // timeout while idle, extremes, backspace, bare ESC, ESC ESC timeout
    add_beat(1'b1, 8'hA5);
    add_beat(1'b0, 8'h00);
    add_beat(1'b0, B_DEL);
    add_beat(1'b0, B_ESC);
    add_beat(1'b1, 8'h00);
    add_beat(1'b0, B_ESC);
    add_beat(1'b0, B_ESC);
    add_beat(1'b1, 8'hFF);
    // ESC [ 1 5 ~ and ESC [ [ E
    add_beat(1'b0, B_ESC);
    add_beat(1'b0, B_LBRACK);
    add_beat(1'b0, B_1);
    add_beat(1'b0, B_5);
    add_beat(1'b0, B_TILDE);
    add_beat(1'b0, B_ESC);
    add_beat(1'b0, B_LBRACK);
    add_beat(1'b0, B_LBRACK);
    add_beat(1'b0, B_E);
    // ESC then lower case, lone FF, longest UTF-8 lead
    add_beat(1'b0, B_ESC);
    add_beat(1'b0, B_LOW_A);
    add_beat(1'b0, 8'hFF);
    add_beat(1'b0, 8'hFD);
    repeat (5) add_beat(1'b0, 8'hBF);

    while (stim_q.size() < NumBeats) add_sequence();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    sent = 0;
    while (sent < stim_q.size()) begin
      @(posedge clk);
      if (byte_ch.valid && byte_ch.ready) sent++;
      if (byte_ch.valid && !byte_ch.ready) begin
        // hold the beat on offer
      end else if (sent < stim_q.size() &&
                   ((sent >= 900 && sent < 1200) || $urandom_range(0, 99) >= 15)) begin
        byte_ch.valid      <= 1'b1;
        byte_ch.op         <= stim_q[sent].op;
        byte_ch.byte_value <= stim_q[sent].data;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end

    // let the checker count the last beat before draining
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errs == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // key sink: random stalls, two long hold-offs, one stretch always ready
  initial begin
    int unsigned cyc;
    int unsigned hold_left;
    key_ch.ready <= 1'b0;
    cyc       = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 60) hold_left = 400;
      if (cyc == 1800) hold_left = 150;
      if (hold_left != 0) begin
        hold_left--;
        key_ch.ready <= 1'b0;
      end else if (cyc >= 2500 && cyc < 3100) begin
        key_ch.ready <= 1'b1;
      end else begin
        key_ch.ready <= ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
